@@ hw/rtl/ray_oriented_box_entry_top_assert.svh @@
// Assertion macros for the checker of the ray/box entry block.
// Depends on nothing; taken in by `include.
`ifndef RAY_ORIENTED_BOX_ENTRY_TOP_ASSERT_SVH
`define RAY_ORIENTED_BOX_ENTRY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ROBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ROBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/robe_pkg.sv @@
// Shared types and constants of the ray/box entry block.
// Used by robe_div_pipe, ray_oriented_box_entry_top and robe_checker; depends on nothing.
package robe_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int DIR_W   = 16;
    localparam int HALF_W  = 31;
    localparam int DIST_W  = 31;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Divisor is |f|, at most 2^31
    localparam int DEN_W   = 32;
    // Signed distance (+/- TMAX)
    localparam int T_W     = DIST_W + 1;

    localparam int DIR_FRAC_BITS_DEF = 14;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_W   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_T   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_H   = 3'd7;

    localparam logic [CFG_W-1:0] AXIS_A_RST = 32'h0000_4000;
    localparam logic [CFG_W-1:0] AXIS_B_RST = 32'h4000_0000;

    localparam logic signed [T_W-1:0] TMAX = {1'b0, {DIST_W{1'b1}}};

    // Running entry/exit interval
    typedef struct packed {
        logic signed [T_W-1:0] tmin;
        logic signed [T_W-1:0] tmax;
        logic                  ok;
    } t_span;

endpackage

@@ hw/rtl/robe_div_pipe.sv @@
// Pipelined unsigned divider: floor(num / den), saturated to 31 bits, one bit a stage.
// Depends on robe_pkg.
module robe_div_pipe
    import robe_pkg::*;
#(
    parameter int NUM_W = 51 + DIR_FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [DIST_W-1:0] o_quo
);

    localparam int HI_W = NUM_W - DIST_W;
    localparam int CW   = HI_W + DEN_W;

    logic [DEN_W-1:0]  r_rem [0:DIST_W];
    logic [DEN_W-1:0]  r_den [0:DIST_W];
    logic [DIST_W-1:0] r_num [0:DIST_W];
    logic [DIST_W-1:0] r_quo [0:DIST_W];
    logic              r_sat [0:DIST_W];

    // First stage: saturation check on the upper bits, start remainder
    logic [HI_W-1:0] hi;
    logic [CW-1:0]   hi_ext;
    logic            n_sat;

    assign hi     = i_num[NUM_W-1:DIST_W];
    assign hi_ext = {{DEN_W{1'b0}}, hi};
    assign n_sat  = hi_ext >= {{HI_W{1'b0}}, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= hi_ext[DEN_W-1:0];
            r_den[0] <= i_den;
            r_num[0] <= i_num[DIST_W-1:0];
            r_quo[0] <= '0;
            r_sat[0] <= n_sat;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= DIST_W; k++) begin : g_stage
        localparam int B = DIST_W - k;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W:0]    diff;
        logic [DIST_W-1:0] n_quo;

        assign trial = {r_rem[k-1], r_num[k-1][B]};
        assign ge    = trial >= {1'b0, r_den[k-1]};
        assign diff  = trial - {1'b0, r_den[k-1]};

        always_comb begin
            n_quo    = r_quo[k-1];
            n_quo[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_den[k] <= r_den[k-1];
                r_num[k] <= r_num[k-1];
                r_quo[k] <= n_quo;
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_quo = r_sat[DIST_W] ? {DIST_W{1'b1}} : r_quo[DIST_W];

endmodule

@@ hw/rtl/ray_oriented_box_entry_top.sv @@
// Ray entry test against an oriented box (slab method), fully pipelined.
// Depends on robe_pkg and robe_div_pipe.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries one ray request: origin
//   (Q.16 metres) and unit direction (Q1.14). Output channel
//   o_out_valid/i_out_ready returns o_hit and o_entry_distance (zero on miss).
//   The box is set through the write port i_cfg_we/i_cfg_idx/i_cfg_data; the user
//   must write it only while no request is in flight (the block does not enforce this).
//   The pipe has 4 front stages (offsets, projections, slab numerators),
//   32 stages of the six bit-serial restoring dividers (one saturation
//   check, then one quotient bit per stage), and 3 stages that order the
//   slab distances, narrow the interval and register the result.
//   Throughput is one ray per cycle while the receiver keeps i_out_ready high.
//   The whole pipe advances together; when the receiver holds i_out_ready
//   low with a result waiting, every stage holds and o_in_ready drops, so
//   nothing is lost or repeated. Synchronous active-low reset empties the
//   pipe and loads the default box registers.
module ray_oriented_box_entry_top
    import robe_pkg::*;
#(
    parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // Ray request
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [POS_W-1:0]  i_origin_x,
    input  logic signed [POS_W-1:0]  i_origin_y,
    input  logic signed [POS_W-1:0]  i_origin_z,
    input  logic signed [DIR_W-1:0]  i_dir_x,
    input  logic signed [DIR_W-1:0]  i_dir_y,
    input  logic signed [DIR_W-1:0]  i_dir_z,
    // Result
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_hit,
    output logic [DIST_W-1:0]        o_entry_distance
);

    localparam int D_W  = POS_W + 1;            // centre - origin
    localparam int PP_W = DIR_W + D_W;          // axis * offset
    localparam int FP_W = 2 * DIR_W;            // axis * direction
    localparam int EW   = PP_W + 1;             // projected offset
    localparam int FW   = FP_W + 1;             // projected direction
    localparam int NW   = EW + 1;               // e -/+ h
    localparam int NUM_W = NW + DIR_FRAC_BITS;  // dividend
    localparam int LAT  = DIST_W + 1;           // divider stages
    localparam logic [FW-1:0] PAR_EPS =
        FW'((64'd1 << (2 * DIR_FRAC_BITS)) / 64'd1000000);

    typedef struct packed {
        logic       vld;
        logic [2:0] par;
        logic [2:0] pmiss;
        logic [2:0] neg_lo;
        logic [2:0] neg_hi;
    } t_ctx;

    logic en;

    // Configuration registers
    logic [CFG_W-1:0]         r_axis_a, r_axis_b;
    logic signed [POS_W-1:0]  r_centre_x, r_centre_y, r_centre_z;
    logic [HALF_W-1:0]        r_half [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_a   <= AXIS_A_RST;
            r_axis_b   <= AXIS_B_RST;
            r_centre_x <= '0;
            r_centre_y <= '0;
            r_centre_z <= '0;
            r_half[0]  <= '0;
            r_half[1]  <= '0;
            r_half[2]  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AXIS_A:   r_axis_a   <= i_cfg_data;
                REG_AXIS_B:   r_axis_b   <= i_cfg_data;
                REG_CENTRE_X: r_centre_x <= i_cfg_data;
                REG_CENTRE_Y: r_centre_y <= i_cfg_data;
                REG_CENTRE_Z: r_centre_z <= i_cfg_data;
                REG_HALF_W:   r_half[0]  <= i_cfg_data[HALF_W-1:0];
                REG_HALF_T:   r_half[1]  <= i_cfg_data[HALF_W-1:0];
                REG_HALF_H:   r_half[2]  <= i_cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [DIR_W-1:0] ax, ay, bx, by;
    assign ax = r_axis_a[DIR_W-1:0];
    assign ay = r_axis_a[CFG_W-1:DIR_W];
    assign bx = r_axis_b[DIR_W-1:0];
    assign by = r_axis_b[CFG_W-1:DIR_W];

    // Pipe advances unless a finished result is held
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: centre offsets
    logic                    r1_vld;
    logic signed [D_W-1:0]   r1_dx, r1_dy, r1_dz;
    logic signed [DIR_W-1:0] r1_ux, r1_uy, r1_uz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= D_W'(r_centre_x) - D_W'(i_origin_x);
            r1_dy <= D_W'(r_centre_y) - D_W'(i_origin_y);
            r1_dz <= D_W'(r_centre_z) - D_W'(i_origin_z);
            r1_ux <= i_dir_x;
            r1_uy <= i_dir_y;
            r1_uz <= i_dir_z;
        end
    end

    // Stage 2: axis products
    logic                     r2_vld;
    logic signed [PP_W-1:0]   r2_pax, r2_pay, r2_pbx, r2_pby;
    logic signed [FP_W-1:0]   r2_fax, r2_fay, r2_fbx, r2_fby;
    logic signed [D_W-1:0]    r2_dz;
    logic signed [DIR_W-1:0]  r2_uz;
    logic signed [PP_W-1:0]   n2_pax, n2_pay, n2_pbx, n2_pby;
    logic signed [FP_W-1:0]   n2_fax, n2_fay, n2_fbx, n2_fby;

    assign n2_pax = PP_W'(ax) * PP_W'(r1_dx);
    assign n2_pay = PP_W'(ay) * PP_W'(r1_dy);
    assign n2_pbx = PP_W'(bx) * PP_W'(r1_dx);
    assign n2_pby = PP_W'(by) * PP_W'(r1_dy);
    assign n2_fax = FP_W'(ax) * FP_W'(r1_ux);
    assign n2_fay = FP_W'(ay) * FP_W'(r1_uy);
    assign n2_fbx = FP_W'(bx) * FP_W'(r1_ux);
    assign n2_fby = FP_W'(by) * FP_W'(r1_uy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pax <= n2_pax;
            r2_pay <= n2_pay;
            r2_pbx <= n2_pbx;
            r2_pby <= n2_pby;
            r2_fax <= n2_fax;
            r2_fay <= n2_fay;
            r2_fbx <= n2_fbx;
            r2_fby <= n2_fby;
            r2_dz  <= r1_dz;
            r2_uz  <= r1_uz;
        end
    end

    // Stage 3: projections e and f per slab
    logic                  r3_vld;
    logic signed [EW-1:0]  r3_e [0:2];
    logic signed [FW-1:0]  r3_f [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_e[0] <= EW'(r2_pax) + EW'(r2_pay);
            r3_e[1] <= EW'(r2_pbx) + EW'(r2_pby);
            r3_e[2] <= EW'(r2_dz) <<< DIR_FRAC_BITS;
            r3_f[0] <= FW'(r2_fax) + FW'(r2_fay);
            r3_f[1] <= FW'(r2_fbx) + FW'(r2_fby);
            r3_f[2] <= FW'(r2_uz) <<< DIR_FRAC_BITS;
        end
    end

    // Stage 4: slab numerators, magnitudes and signs, parallel check
    t_ctx               n4_ctx;
    t_ctx               r4_ctx;
    logic [NUM_W-1:0]   n4_num_lo [0:2];
    logic [NUM_W-1:0]   n4_num_hi [0:2];
    logic [DEN_W-1:0]   n4_den    [0:2];
    logic [NUM_W-1:0]   r4_num_lo [0:2];
    logic [NUM_W-1:0]   r4_num_hi [0:2];
    logic [DEN_W-1:0]   r4_den    [0:2];

    always_comb begin
        logic signed [NW-1:0] h, e, lo, hi;
        logic [NW-1:0]        alo, ahi;
        logic [FW-1:0]        af;
        n4_ctx     = '0;
        n4_ctx.vld = r3_vld;
        for (int s = 0; s < 3; s++) begin
            h   = $signed({{(NW - HALF_W - DIR_FRAC_BITS){1'b0}}, r_half[s],
                           {DIR_FRAC_BITS{1'b0}}});
            e   = NW'(r3_e[s]);
            lo  = e - h;
            hi  = e + h;
            alo = lo[NW-1] ? -lo : lo;
            ahi = hi[NW-1] ? -hi : hi;
            af  = r3_f[s][FW-1] ? -r3_f[s] : r3_f[s];
            n4_num_lo[s]    = {alo, {DIR_FRAC_BITS{1'b0}}};
            n4_num_hi[s]    = {ahi, {DIR_FRAC_BITS{1'b0}}};
            n4_den[s]       = af[DEN_W-1:0];
            n4_ctx.par[s]   = af <= PAR_EPS;
            n4_ctx.pmiss[s] = (e < -h) || (e > h);
            n4_ctx.neg_lo[s] = lo[NW-1] ^ r3_f[s][FW-1];
            n4_ctx.neg_hi[s] = hi[NW-1] ^ r3_f[s][FW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctx <= '0;
        end else if (en) begin
            r4_ctx <= n4_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < 3; s++) begin
                r4_num_lo[s] <= n4_num_lo[s];
                r4_num_hi[s] <= n4_num_hi[s];
                r4_den[s]    <= n4_den[s];
            end
        end
    end

    // Dividers, one pair per slab
    logic [DIST_W-1:0] mag_lo [0:2];
    logic [DIST_W-1:0] mag_hi [0:2];

    for (genvar s = 0; s < 3; s++) begin : g_div
        robe_div_pipe #(.NUM_W(NUM_W)) u_div_lo (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r4_num_lo[s]),
            .i_den (r4_den[s]),
            .o_quo (mag_lo[s])
        );
        robe_div_pipe #(.NUM_W(NUM_W)) u_div_hi (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r4_num_hi[s]),
            .i_den (r4_den[s]),
            .o_quo (mag_hi[s])
        );
    end

    // Context travels alongside the dividers
    t_ctx r_ctx [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_ctx[k] <= '0;
            end
        end else if (en) begin
            r_ctx[0] <= r4_ctx;
            for (int k = 1; k < LAT; k++) begin
                r_ctx[k] <= r_ctx[k-1];
            end
        end
    end

    // Post stage 1: signed distances, ordered near/far per slab
    t_ctx                  r5_ctx;
    logic signed [T_W-1:0] r5_t1 [0:2];
    logic signed [T_W-1:0] r5_t2 [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctx <= '0;
        end else if (en) begin
            r5_ctx <= r_ctx[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [T_W-1:0] tl, th;
        if (en) begin
            for (int s = 0; s < 3; s++) begin
                tl = r_ctx[LAT-1].neg_lo[s] ? -$signed({1'b0, mag_lo[s]})
                                            :  $signed({1'b0, mag_lo[s]});
                th = r_ctx[LAT-1].neg_hi[s] ? -$signed({1'b0, mag_hi[s]})
                                            :  $signed({1'b0, mag_hi[s]});
                r5_t1[s] <= (tl > th) ? th : tl;
                r5_t2[s] <= (tl > th) ? tl : th;
            end
        end
    end

    // Narrow the interval by one slab
    function automatic t_span slab_upd(t_span sp, logic par, logic pmiss,
                                       logic signed [T_W-1:0] t1,
                                       logic signed [T_W-1:0] t2);
        t_span o;
        o = sp;
        if (par) begin
            o.ok = sp.ok && !pmiss;
        end else begin
            if (t1 > sp.tmin) o.tmin = t1;
            if (t2 < sp.tmax) o.tmax = t2;
            o.ok = sp.ok && (o.tmin <= o.tmax);
        end
        return o;
    endfunction

    // Post stage 2: the two horizontal slabs
    logic  r6_vld;
    t_span r6_span;
    logic  r6_par_z, r6_pmiss_z;
    logic signed [T_W-1:0] r6_t1_z, r6_t2_z;
    t_span n6_span;

    always_comb begin
        t_span sp;
        sp.tmin = '0;
        sp.tmax = TMAX;
        sp.ok   = 1'b1;
        sp = slab_upd(sp, r5_ctx.par[0], r5_ctx.pmiss[0], r5_t1[0], r5_t2[0]);
        sp = slab_upd(sp, r5_ctx.par[1], r5_ctx.pmiss[1], r5_t1[1], r5_t2[1]);
        n6_span = sp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_ctx.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_span    <= n6_span;
            r6_par_z   <= r5_ctx.par[2];
            r6_pmiss_z <= r5_ctx.pmiss[2];
            r6_t1_z    <= r5_t1[2];
            r6_t2_z    <= r5_t2[2];
        end
    end

    // Post stage 3: vertical slab and result register
    t_span             n7_span;
    logic              n7_hit;
    logic              r_out_vld;
    logic              r_hit;
    logic [DIST_W-1:0] r_dist;

    assign n7_span = slab_upd(r6_span, r6_par_z, r6_pmiss_z, r6_t1_z, r6_t2_z);
    assign n7_hit  = n7_span.ok && (n7_span.tmin > 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit  <= n7_hit;
            r_dist <= n7_hit ? n7_span.tmin[DIST_W-1:0] : '0;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_hit            = r_hit;
    assign o_entry_distance = r_dist;

endmodule

@@ hw/rtl/robe_checker.sv @@
// Port-level checker for ray_oriented_box_entry_top, bound to the top level.
// Depends on robe_pkg and ray_oriented_box_entry_top_assert.svh.
`include "ray_oriented_box_entry_top_assert.svh"

module robe_checker
    import robe_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_hit,
    input logic [DIST_W-1:0] o_entry_distance
);

    // A miss always reports zero distance
    `ROBE_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_hit, o_entry_distance == '0, "miss with nonzero distance")

    // A hit lies strictly ahead of the origin
    `ROBE_ASSERT_NOW(a_hit_ahead, i_clk, i_rst_n, o_out_valid && o_hit, o_entry_distance != '0, "hit at zero distance")

    // With no result waiting the pipe must take requests
    `ROBE_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_out_valid, o_in_ready, "ready low with empty output")

    // A stalled result stays presented
    `ROBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_hit) && $stable(o_entry_distance), "stalled result changed")

endmodule

bind ray_oriented_box_entry_top robe_checker u_robe_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_hit            (o_hit),
    .o_entry_distance (o_entry_distance)
);
